/* rtl/f8cv_pkg.sv */
// ----------------------------------------------------------------------------
// f8cv_pkg
// shared types and constants for the e4m3 / float32 converter
// ----------------------------------------------------------------------------
package f8cv_pkg;

	localparam int unsigned WordWidth = 32;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// classification of an encode word after the first stage
	typedef enum logic [2:0] {
		CL_ZERO,
		CL_NAN,
		CL_SAT,
		CL_SUB,
		CL_NORM
	} cls_t;

	// stage 1 -> stage 2 payload
	typedef struct packed {
		op_t         op;
		logic        sign;
		cls_t        cls;
		logic [3:0]  ne;      // normal exponent, or subnormal shift 1..4
		logic [23:0] full;    // mantissa with implicit one
		logic [7:0]  byte_in; // decode byte
	} s1_t;

	// stage 2 -> stage 3 payload
	typedef struct packed {
		op_t         op;
		logic        sign;
		cls_t        cls;
		logic [6:0]  packed_code; // exp and kept bits before rounding
		logic        rnd_up;
		logic [7:0]  byte_in;
	} s2_t;

	localparam logic [6:0] CodeNan = 7'h7F;
	localparam logic [6:0] CodeMax = 7'h7E;

endpackage

/* rtl/f8cv_stage.sv */
// ----------------------------------------------------------------------------
// f8cv_stage
// one pipeline register stage with valid and stall
// ----------------------------------------------------------------------------
module f8cv_stage #(
	parameter int unsigned Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [Width-1:0] in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [Width-1:0] out_data
);
	logic valid_q;
	logic [Width-1:0] data_q;

	// stage accepts whenever empty or draining
	assign in_stall  = valid_q & out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_q <= in_data;
		end
	end
endmodule

/* rtl/f8cv_front.sv */
// ----------------------------------------------------------------------------
// f8cv_front
// combinational logic of the three stages
// ----------------------------------------------------------------------------
module f8cv_front (
	input  logic                 op,
	input  logic [31:0]          value,
	output f8cv_pkg::s1_t        s1,
	input  f8cv_pkg::s1_t        s1_in,
	output f8cv_pkg::s2_t        s2,
	input  f8cv_pkg::s2_t        s2_in,
	output logic [31:0]          res
);
	// stage 1: classify
	logic [7:0] e;
	logic [9:0] ne;
	always_comb begin
		e  = value[30:23];
		ne = {2'b00, e} - 10'd120;
		s1 = '0;
		s1.op      = f8cv_pkg::op_t'(op);
		s1.sign    = value[31];
		s1.full    = {1'b1, value[22:0]};
		s1.byte_in = value[7:0];
		if (e == 8'hFF) s1.cls = f8cv_pkg::CL_NAN;
		else if (e == 8'h00) s1.cls = f8cv_pkg::CL_ZERO;
		else if (!ne[9] && ne > 10'd15) s1.cls = f8cv_pkg::CL_SAT;
		else if (!ne[9] && ne != 10'd0) begin
			s1.cls = f8cv_pkg::CL_NORM;
			s1.ne  = ne[3:0];
		end else if (ne == 10'd0 || ne >= 10'h3FD) begin
			s1.cls = f8cv_pkg::CL_SUB;
			s1.ne  = 4'(10'd1 - ne);
		end else s1.cls = f8cv_pkg::CL_ZERO;
	end

	// stage 2: align and decide rounding
	logic [23:0] m;
	logic        sticky;
	logic [19:0] rem;
	always_comb begin
		m = s1_in.full >> s1_in.ne[2:0];
		sticky = 1'b0;
		unique case (s1_in.ne[2:0])
			3'd1: sticky = s1_in.full[0];
			3'd2: sticky = |s1_in.full[1:0];
			3'd3: sticky = |s1_in.full[2:0];
			3'd4: sticky = |s1_in.full[3:0];
			default: sticky = 1'b0;
		endcase
		s2 = '0;
		s2.op      = s1_in.op;
		s2.sign    = s1_in.sign;
		s2.cls     = s1_in.cls;
		s2.byte_in = s1_in.byte_in;
		if (s1_in.cls == f8cv_pkg::CL_SUB) begin
			rem = m[19:0];
			s2.packed_code = {4'd0, m[22:20]};
			s2.rnd_up = rem[19] & ((|rem[18:0]) | sticky | m[20]);
		end else begin
			rem = s1_in.full[19:0];
			s2.packed_code = {s1_in.ne, s1_in.full[22:20]};
			s2.rnd_up = rem[19] & ((|rem[18:0]) | s1_in.full[20]);
		end
	end

	// stage 3: round, saturate, decode
	logic [7:0] pk;
	logic [6:0] code;
	logic [3:0] de;
	logic [2:0] dm, fm3;
	logic [7:0] fe;
	always_comb begin
		pk = {1'b0, s2_in.packed_code} + {7'd0, s2_in.rnd_up};
		unique case (s2_in.cls)
			f8cv_pkg::CL_NAN:  code = f8cv_pkg::CodeNan;
			f8cv_pkg::CL_SAT:  code = f8cv_pkg::CodeMax;
			f8cv_pkg::CL_ZERO: code = 7'd0;
			f8cv_pkg::CL_SUB:  code = pk[6:0];
			default: code = (pk[7] || pk[6:0] == f8cv_pkg::CodeNan) ? f8cv_pkg::CodeMax
				: pk[6:0];
		endcase
		de = s2_in.byte_in[6:3];
		dm = s2_in.byte_in[2:0];
		fm3 = 3'd0;
		fe  = 8'd0;
		if (de == 4'd0) begin
			priority if (dm[2]) begin
				fe = 8'd120; fm3 = {dm[1:0], 1'b0};
			end else if (dm[1]) begin
				fe = 8'd119; fm3 = {dm[0], 2'b00};
			end else if (dm[0]) begin
				fe = 8'd118; fm3 = 3'd0;
			end else begin
				fe = 8'd0; fm3 = 3'd0;
			end
		end else if (de == 4'hF && dm == 3'h7) begin
			fe = 8'hFF; fm3 = 3'h7;
		end else begin
			fe = {4'd0, de} + 8'd120; fm3 = dm;
		end
		if (s2_in.op == f8cv_pkg::OP_DECODE)
			res = {s2_in.byte_in[7], fe, fm3, 20'd0};
		else
			res = {24'd0, s2_in.sign, code};
	end
endmodule

/* rtl/fp8_e4m3_float32_converter_unit.sv */
// ----------------------------------------------------------------------------
// fp8_e4m3_float32_converter_unit
// fp8 e4m3 <-> float32 converter, three-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   input channel: valid, stall, operation, value (one word per conversion)
//   operation low encodes a float32 word to e4m3 (byte in result[7:0]),
//   operation high decodes value[7:0] as e4m3 to float32
//   output channel: out_valid, out_stall, result
// timing
//   throughput one word per cycle while the receiver does not stall; each stage register holds one word
//   stage 1 classifies, stage 2 aligns and finds the rounding bit,
//   stage 3 rounds, saturates and builds the decoded word
// reset
//   arst_n clears all valid bits; the pipeline comes up empty
// stall
//   a stall from the receiver holds the last stage; earlier stages keep
//   filling until full, then stall propagates back to the sender
// ----------------------------------------------------------------------------
module fp8_e4m3_float32_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic        operation,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result
);
	localparam int unsigned S1W = $bits(f8cv_pkg::s1_t);
	localparam int unsigned S2W = $bits(f8cv_pkg::s2_t);

	f8cv_pkg::s1_t s1_d, s1_q;
	f8cv_pkg::s2_t s2_d, s2_q;
	logic [31:0]   res_d;
	logic          v1, v2, st1, st2;
	logic [S1W-1:0] s1_bits;
	logic [S2W-1:0] s2_bits;

	// shared combinational datapath of all stages
	f8cv_front u_front (
		.op(operation), .value(value), .s1(s1_d), .s1_in(s1_q),
		.s2(s2_d), .s2_in(s2_q), .res(res_d)
	);

	// stage 1 register
	f8cv_stage #(.Width(S1W)) u_s1 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid), .in_stall(stall),
		.in_data(s1_d), .out_valid(v1), .out_stall(st1), .out_data(s1_bits)
	);
	assign s1_q = f8cv_pkg::s1_t'(s1_bits);

	// stage 2 register
	f8cv_stage #(.Width(S2W)) u_s2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v1), .in_stall(st1),
		.in_data(s2_d), .out_valid(v2), .out_stall(st2), .out_data(s2_bits)
	);
	assign s2_q = f8cv_pkg::s2_t'(s2_bits);

	// stage 3 output register
	f8cv_stage #(.Width(32)) u_s3 (
		.clk(clk), .arst_n(arst_n), .in_valid(v2), .in_stall(st2),
		.in_data(res_d), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(result)
	);
endmodule

/* rtl/f8cv_checker.sv */
// ----------------------------------------------------------------------------
// f8cv_checker
// port-level checks of the converter
// ----------------------------------------------------------------------------
module f8cv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result
);
	// output word held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("result changed under stall");

	// no stall towards the sender while the output is free
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !stall)
		else $error("input stalled with free output");

	// an accepted word reaches the output when the receiver never stalls meanwhile
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("word lost in pipeline");
endmodule

bind fp8_e4m3_float32_converter_unit f8cv_checker u_chk (
	.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
	.out_valid(out_valid), .out_stall(out_stall), .result(result)
);

/* tb/sv/fp8_e4m3_float32_converter_unit_test.sv */
// ----------------------------------------------------------------------------
// fp8_e4m3_float32_converter_unit_test
// self-checking bench for the e4m3 / float32 converter: a directed table of
// edge values, then random words, all checked in order against a predictor
// ----------------------------------------------------------------------------
module fp8_e4m3_float32_converter_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandomWords = 400;
	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned HoldCycles = 40;

	// one directed row; check_fixed says the expected word is typed in
	typedef struct {
		f8cv_pkg::op_t op;
		logic [31:0]   word_in;
		logic          check_fixed;
		logic [31:0]   fixed_res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        stall;
	logic        operation = 1'b0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result;

	logic [31:0] pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	bit          hold_request = 1'b0;
	bit          holding = 1'b0;

	row_t directed_rows[] = '{
		'{f8cv_pkg::OP_ENCODE, 32'h0000_0000, 1'b1, 32'h00},   // plus zero
		'{f8cv_pkg::OP_ENCODE, 32'h8000_0000, 1'b1, 32'h80},   // minus zero
		'{f8cv_pkg::OP_ENCODE, 32'h0000_0001, 1'b1, 32'h00},   // float32 denormal flushes
		'{f8cv_pkg::OP_ENCODE, 32'h807F_FFFF, 1'b1, 32'h80},
		'{f8cv_pkg::OP_ENCODE, 32'h7F80_0000, 1'b1, 32'h7F},   // infinity to nan
		'{f8cv_pkg::OP_ENCODE, 32'hFFC0_0001, 1'b1, 32'hFF},   // nan keeps sign
		'{f8cv_pkg::OP_ENCODE, 32'h7F7F_FFFF, 1'b1, 32'h7E},   // huge saturates
		'{f8cv_pkg::OP_ENCODE, 32'h43E0_0000, 1'b1, 32'h7E},   // 448 itself
		'{f8cv_pkg::OP_ENCODE, 32'h43F0_0000, 1'b1, 32'h7E},   // 480 would be nan code
		'{f8cv_pkg::OP_ENCODE, 32'h4380_0000, 1'b1, 32'h78},   // 256
		'{f8cv_pkg::OP_ENCODE, 32'hC3D0_0000, 1'b0, 32'h0},    // -416 in range
		'{f8cv_pkg::OP_ENCODE, 32'h3F80_0000, 1'b1, 32'h38},   // one
		'{f8cv_pkg::OP_ENCODE, 32'h3F88_0000, 1'b0, 32'h0},    // tie to even
		'{f8cv_pkg::OP_ENCODE, 32'h3F98_0000, 1'b0, 32'h0},
		'{f8cv_pkg::OP_ENCODE, 32'h3B00_0000, 1'b1, 32'h01},   // smallest subnormal
		'{f8cv_pkg::OP_ENCODE, 32'h3A80_0000, 1'b0, 32'h0},    // exact half of it, ties even
		'{f8cv_pkg::OP_ENCODE, 32'h3A80_0001, 1'b0, 32'h0},    // half plus sticky
		'{f8cv_pkg::OP_ENCODE, 32'h3C7F_FFFF, 1'b0, 32'h0},    // carry into smallest normal
		'{f8cv_pkg::OP_ENCODE, 32'h3A00_0000, 1'b1, 32'h00},   // far below subnormal range
		'{f8cv_pkg::OP_DECODE, 32'hFFFF_FF00, 1'b1, 32'h0},    // upper bits ignored
		'{f8cv_pkg::OP_DECODE, 32'h0000_007F, 1'b1, 32'h7FF0_0000},
		'{f8cv_pkg::OP_DECODE, 32'h0000_00FF, 1'b1, 32'hFFF0_0000},
		'{f8cv_pkg::OP_DECODE, 32'h0000_007E, 1'b1, 32'h43E0_0000},
		'{f8cv_pkg::OP_DECODE, 32'h0000_0081, 1'b1, 32'hBB00_0000},
		'{f8cv_pkg::OP_DECODE, 32'h0000_0003, 1'b0, 32'h0}
	};

	fp8_e4m3_float32_converter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid),
		.stall    (stall),
		.operation(operation),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

	always #2 clk = ~clk;

	// float32 to e4m3, nearest even, saturating at 448
	function automatic logic [7:0] to_e4m3(input logic [31:0] fb);
		logic        sgn;
		logic [7:0]  fexp;
		logic [22:0] frac;
		int          unb;
		logic [23:0] full;
		logic [23:0] shifted;
		logic        sticky;
		logic [3:0]  kept;
		logic [19:0] rem;
		logic [7:0]  code;
		int unsigned sh;
		sgn = fb[31];
		fexp = fb[30:23];
		frac = fb[22:0];
		unb = int'(fexp) - 120;
		if (fexp == 8'hFF) begin
			code = 8'h7F;
		end else if (fexp == 8'h00) begin
			code = 8'h00;
		end else if (unb > 15) begin
			code = 8'h7E;
		end else if (unb <= 0) begin
			if (unb >= -3) begin
				full = {1'b1, frac};
				sh = 1 - unb;
				shifted = full >> sh;
				sticky = (full & ((24'd1 << sh) - 24'd1)) != 0;
				kept = {1'b0, shifted[22:20]};
				rem = shifted[19:0];
				if (rem > 20'h80000 || (rem == 20'h80000 && (sticky || kept[0])))
					kept = kept + 1;
				code = {4'b0, kept};
			end else begin
				code = 8'h00;
			end
		end else begin
			code = {1'b0, unb[3:0], frac[22:20]};
			rem = frac[19:0];
			if (rem > 20'h80000 || (rem == 20'h80000 && code[0]))
				code = code + 1;
			if (code >= 8'h7F)
				code = 8'h7E;
		end
		return {sgn, code[6:0]};
	endfunction

	// e4m3 to float32, exact
	function automatic logic [31:0] from_e4m3(input logic [7:0] b);
		logic [3:0]  bexp;
		logic [2:0]  m;
		logic [7:0]  fexp;
		logic [22:0] frac;
		bexp = b[6:3];
		m = b[2:0];
		if (bexp == 4'h0 && m == 3'd0) begin
			fexp = 8'd0;
			frac = '0;
		end else if (bexp == 4'h0) begin
			fexp = 8'd120;
			while (!m[2]) begin
				m = m << 1;
				fexp = fexp - 1;
			end
			// leading one dropped, the rest becomes the fraction
			frac = {m[1:0], 21'd0};
		end else if (b[6:0] == f8cv_pkg::CodeNan) begin
			fexp = 8'hFF;
			frac = 23'h700000;
		end else begin
			fexp = {4'd0, bexp} + 8'd120;
			frac = {m, 20'd0};
		end
		return {b[7], fexp, frac};
	endfunction

	function automatic logic [31:0] converted_word(input f8cv_pkg::op_t op,
			input logic [31:0] w);
		if (op == f8cv_pkg::OP_DECODE)
			return from_e4m3(w[7:0]);
		return {24'd0, to_e4m3(w)};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %08h want %08h", what, got, want);
		mismatch_count++;
	endtask

	// random gap, mostly short, now and then long
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// hand one word over, holding it steady while stalled
	task automatic send_word(input f8cv_pkg::op_t op, input logic [31:0] w);
		int unsigned g;
		g = gap_length();
		if (g != 0) begin
			valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		valid <= 1'b1;
		operation <= op;
		value <= w;
		pending_results.push_back(converted_word(op, w));
		@(posedge clk);
		while (stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random encode input: mostly near e4m3 range, with full-range noise
	function automatic logic [31:0] random_float();
		logic [31:0] w;
		int unsigned r;
		w = $urandom();
		r = $urandom_range(0, 9);
		if (r < 6)
			w[30:23] = $urandom_range(112, 136);
		else if (r == 6)
			w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return w;
	endfunction

	// receiver: random stalls, plus one long hold when asked
	initial begin
		int unsigned g;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !holding) begin
				holding = 1'b1;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(negedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
				holding = 1'b0;
			end else begin
				g = gap_length();
				if (g != 0) begin
					out_stall <= 1'b1;
					repeat (g - 1) @(negedge clk);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", result, 32'h0);
			end else begin
				logic [31:0] want;
				want = pending_results.pop_front();
				if (result !== want)
					report_mismatch("result", result, want);
			end
		end
	end

	// watchdog: counts cycles with no handshake on either side
	always @(posedge clk) begin
		if ((valid && !stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [31:0]   w;
		f8cv_pkg::op_t op;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed table, typed-in values first, then the predictor
		foreach (directed_rows[i]) begin
			if (directed_rows[i].check_fixed
					&& converted_word(directed_rows[i].op, directed_rows[i].word_in)
					!== directed_rows[i].fixed_res)
				report_mismatch("predictor row", converted_word(directed_rows[i].op,
					directed_rows[i].word_in), directed_rows[i].fixed_res);
			send_word(directed_rows[i].op, directed_rows[i].word_in);
		end
		// long receiver hold while words keep coming, so the pipe backs up
		hold_request = 1'b1;
		for (int i = 0; i < RandomWords; i++) begin
			op = $urandom_range(0, 1) ? f8cv_pkg::OP_DECODE : f8cv_pkg::OP_ENCODE;
			w = (op == f8cv_pkg::OP_DECODE) ? $urandom() : random_float();
			send_word(op, w);
			// one pause until everything has drained
			if (i == RandomWords / 2) begin
				valid <= 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
			end
		end
		valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
